### sv/cll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types, codes and constants of the command line lexer.
// ----------------------------------------------------------------------------
package cll_pkg;

    // Longest line the column counter tracks; columns saturate at COL_TOP.
    localparam int LINE_MAX = 4096;
    localparam int COL_W    = 12;
    localparam int SPAN_W   = 13;
    localparam logic [COL_W-1:0] COL_TOP =
        COL_W'((LINE_MAX - 1 < 4095) ? LINE_MAX - 1 : 4095);

    // Results one character can cause, and the result queue behind the lexer.
    localparam int RES_MAX    = 3;
    localparam int CNT_W      = $clog2(RES_MAX + 1);
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_MINUS,
        MODE_ERROR
    } t_mode;

    typedef enum logic [2:0] {
        ST_TOKEN      = 3'd0,
        ST_BAD_CHAR   = 3'd1,
        ST_BAD_MINUS  = 3'd2,
        ST_TWO_POINTS = 3'd3,
        ST_LINE_END   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_EQUALS = 3'd1,
        KIND_OPER   = 3'd2,
        KIND_LPAREN = 3'd3,
        KIND_RPAREN = 3'd4,
        KIND_NUMBER = 3'd5,
        KIND_COMMA  = 3'd6
    } t_kind;

    typedef struct packed {
        t_status             status;
        t_kind               kind;
        logic [COL_W-1:0]    col;
        logic [SPAN_W-1:0]   span;
        logic                last;
    } t_res;

    // Results of one character, all written to the queue in the same cycle
    typedef struct packed {
        logic [CNT_W-1:0]      cnt;
        t_res [RES_MAX-1:0]    res;
    } t_wr;

    function automatic t_res make_res(t_status s, t_kind k,
                                      logic [COL_W-1:0] c, logic [SPAN_W-1:0] l);
        t_res r;
        r.status = s;
        r.kind   = k;
        r.col    = c;
        r.span   = l;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

### sv/cll_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_char_if / cll_result_if
// Valid/ready channels for characters in and lexer results out.
// ----------------------------------------------------------------------------
interface cll_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_last;

    modport source (output valid, output char_code, output line_last, input ready);
    modport sink   (input valid, input char_code, input line_last, output ready);
endinterface

interface cll_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  token_kind;
    logic [11:0] start_col;
    logic [12:0] span_len;
    logic        result_last;

    modport source (output valid, output status, output token_kind, output start_col,
                    output span_len, output result_last, input ready);
    modport sink   (input valid, input status, input token_kind, input start_col,
                    input span_len, input result_last, output ready);
endinterface

### sv/cll_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_core
// Input register, lexer state and the one-character step; hands up to three
// results per character to the result queue.
// ----------------------------------------------------------------------------
module cll_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    cll_char_if.sink                 i_char,
    input  logic [cll_pkg::FIFO_AW:0] i_fill,
    output cll_pkg::t_wr             o_wr
);

    localparam int NEED_W = cll_pkg::FIFO_AW + 2;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // lexer state
    cll_pkg::t_mode                  r_mode, n_mode;
    logic [cll_pkg::COL_W-1:0]       r_col, n_col;
    logic [cll_pkg::COL_W-1:0]       r_begin, n_begin;
    logic                            r_point, n_point;

    logic                            w_accept;
    logic [NEED_W-1:0]               w_need;

    // character classes
    logic w_letter, w_digit, w_space, w_point, w_minus, w_under;

    // classification of a character that starts fresh
    logic                            cls_emit;
    cll_pkg::t_res                   cls_res;
    cll_pkg::t_mode                  cls_mode;
    logic                            cls_start;

    // step results
    cll_pkg::t_res [cll_pkg::RES_MAX-1:0] v_res;
    logic [cll_pkg::CNT_W-1:0]       v_cnt;
    logic                            v_reclass;
    logic [cll_pkg::SPAN_W-1:0]      w_span_open;
    logic [cll_pkg::SPAN_W-1:0]      v_span_close;

    // Worst case the queued word plus the one in the input register
    // each add RES_MAX results.
    assign w_need = NEED_W'(i_fill) + (r_in_valid ? NEED_W'(cll_pkg::RES_MAX) : '0);
    assign i_char.ready = (w_need <= NEED_W'(cll_pkg::FIFO_DEPTH - cll_pkg::RES_MAX));
    assign w_accept = i_char.valid && i_char.ready;

    assign w_letter = ((r_in_char >= cll_pkg::CH_UC_A) && (r_in_char <= cll_pkg::CH_UC_Z)) ||
                      ((r_in_char >= cll_pkg::CH_LC_A) && (r_in_char <= cll_pkg::CH_LC_Z));
    assign w_digit  = (r_in_char >= cll_pkg::CH_0) && (r_in_char <= cll_pkg::CH_9);
    assign w_space  = (r_in_char == cll_pkg::CH_SPACE) || (r_in_char == cll_pkg::CH_NL) ||
                      (r_in_char == cll_pkg::CH_TAB);
    assign w_point  = (r_in_char == cll_pkg::CH_POINT);
    assign w_minus  = (r_in_char == cll_pkg::CH_MINUS);
    assign w_under  = (r_in_char == cll_pkg::CH_UNDER);

    assign w_span_open = {1'b0, r_col} - {1'b0, r_begin};

    always_comb begin
        cls_emit  = 1'b0;
        cls_res   = cll_pkg::make_res(cll_pkg::ST_TOKEN, cll_pkg::KIND_IDENT, r_col,
                                      cll_pkg::SPAN_W'(1));
        cls_mode  = cll_pkg::MODE_IDLE;
        cls_start = 1'b0;
        priority if (w_space) begin
        end else if (r_in_char == cll_pkg::CH_LPAREN) begin
            cls_emit     = 1'b1;
            cls_res.kind = cll_pkg::KIND_LPAREN;
        end else if (r_in_char == cll_pkg::CH_RPAREN) begin
            cls_emit     = 1'b1;
            cls_res.kind = cll_pkg::KIND_RPAREN;
        end else if (r_in_char == cll_pkg::CH_COMMA) begin
            cls_emit     = 1'b1;
            cls_res.kind = cll_pkg::KIND_COMMA;
        end else if (r_in_char == cll_pkg::CH_EQUALS) begin
            cls_emit     = 1'b1;
            cls_res.kind = cll_pkg::KIND_EQUALS;
        end else if ((r_in_char == cll_pkg::CH_PLUS) || (r_in_char == cll_pkg::CH_STAR)) begin
            cls_emit     = 1'b1;
            cls_res.kind = cll_pkg::KIND_OPER;
        end else if (w_minus) begin
            cls_mode  = cll_pkg::MODE_MINUS;
            cls_start = 1'b1;
        end else if (w_letter) begin
            cls_mode  = cll_pkg::MODE_IDENT;
            cls_start = 1'b1;
        end else if (w_digit || w_point) begin
            cls_mode  = cll_pkg::MODE_NUMBER;
            cls_start = 1'b1;
        end else begin
            cls_emit       = 1'b1;
            cls_res.status = cll_pkg::ST_BAD_CHAR;
            cls_mode       = cll_pkg::MODE_ERROR;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_begin      = r_begin;
        n_point      = r_point;
        n_col        = r_col;
        v_res        = '0;
        v_cnt        = '0;
        v_reclass    = 1'b0;
        v_span_close = '0;

        unique case (r_mode)
            cll_pkg::MODE_IDENT: begin
                if (!(w_letter || w_digit || w_under)) begin
                    v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_TOKEN, cll_pkg::KIND_IDENT,
                                                     r_begin, w_span_open);
                    v_cnt     = v_cnt + cll_pkg::CNT_W'(1);
                    v_reclass = 1'b1;
                end
            end
            cll_pkg::MODE_NUMBER: begin
                if (w_digit) begin
                end else if (w_point) begin
                    if (r_point) begin
                        v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_TWO_POINTS,
                                                         cll_pkg::KIND_IDENT, r_begin,
                                                         w_span_open + cll_pkg::SPAN_W'(1));
                        v_cnt  = v_cnt + cll_pkg::CNT_W'(1);
                        n_mode = cll_pkg::MODE_ERROR;
                    end else begin
                        n_point = 1'b1;
                    end
                end else begin
                    v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_TOKEN, cll_pkg::KIND_NUMBER,
                                                     r_begin, w_span_open);
                    v_cnt     = v_cnt + cll_pkg::CNT_W'(1);
                    v_reclass = 1'b1;
                end
            end
            cll_pkg::MODE_MINUS: begin
                if (w_digit || w_point) begin
                    n_mode  = cll_pkg::MODE_NUMBER;
                    n_point = w_point;
                end else if (w_minus) begin
                    v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_BAD_MINUS, cll_pkg::KIND_IDENT,
                                                     r_begin, cll_pkg::SPAN_W'(1));
                    v_cnt  = v_cnt + cll_pkg::CNT_W'(1);
                    n_mode = cll_pkg::MODE_ERROR;
                end else begin
                    v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_TOKEN, cll_pkg::KIND_OPER,
                                                     r_begin, cll_pkg::SPAN_W'(1));
                    v_cnt     = v_cnt + cll_pkg::CNT_W'(1);
                    v_reclass = 1'b1;
                end
            end
            cll_pkg::MODE_ERROR: begin
            end
            default: begin
                v_reclass = 1'b1;
            end
        endcase

        if (v_reclass) begin
            n_mode = cls_mode;
            if (cls_emit) begin
                v_res[v_cnt] = cls_res;
                v_cnt        = v_cnt + cll_pkg::CNT_W'(1);
            end
            if (cls_start) begin
                n_begin = r_col;
            end
            if (cls_mode == cll_pkg::MODE_NUMBER) begin
                n_point = w_point;
            end
        end

        if (r_in_last) begin
            // flush an open token, then close the line
            v_span_close = {1'b0, r_col} - {1'b0, n_begin} + cll_pkg::SPAN_W'(1);
            if (n_mode == cll_pkg::MODE_IDENT) begin
                v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_TOKEN, cll_pkg::KIND_IDENT,
                                                 n_begin, v_span_close);
                v_cnt = v_cnt + cll_pkg::CNT_W'(1);
            end else if (n_mode == cll_pkg::MODE_NUMBER) begin
                v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_TOKEN, cll_pkg::KIND_NUMBER,
                                                 n_begin, v_span_close);
                v_cnt = v_cnt + cll_pkg::CNT_W'(1);
            end else if (n_mode == cll_pkg::MODE_MINUS) begin
                v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_BAD_MINUS, cll_pkg::KIND_IDENT,
                                                 n_begin, cll_pkg::SPAN_W'(1));
                v_cnt = v_cnt + cll_pkg::CNT_W'(1);
            end
            v_res[v_cnt] = cll_pkg::make_res(cll_pkg::ST_LINE_END, cll_pkg::KIND_IDENT,
                                             '0, '0);
            v_cnt   = v_cnt + cll_pkg::CNT_W'(1);
            n_mode  = cll_pkg::MODE_IDLE;
            n_col   = '0;
            n_point = 1'b0;
        end else begin
            n_col = (r_col < cll_pkg::COL_TOP) ? r_col + cll_pkg::COL_W'(1) : cll_pkg::COL_TOP;
        end

        if (v_cnt != '0) begin
            v_res[v_cnt - cll_pkg::CNT_W'(1)].last = 1'b1;
        end
    end

    assign o_wr.cnt = r_in_valid ? v_cnt : '0;
    assign o_wr.res = v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= cll_pkg::MODE_IDLE;
            r_col      <= '0;
            r_begin    <= '0;
            r_point    <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
            if (r_in_valid) begin
                r_mode  <= n_mode;
                r_col   <= n_col;
                r_begin <= n_begin;
                r_point <= n_point;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.line_last;
        end
    end

endmodule

### sv/cll_rfifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cll_rfifo
// Result queue: takes up to three results a cycle, gives one word a cycle while the sink is ready.
// ----------------------------------------------------------------------------
module cll_rfifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cll_pkg::t_wr              i_wr,
    output logic [cll_pkg::FIFO_AW:0] o_fill,
    cll_result_if.source              o_result
);

    cll_pkg::t_res                  r_mem [cll_pkg::FIFO_DEPTH];
    logic [cll_pkg::FIFO_AW-1:0]    r_wr_ptr;
    logic [cll_pkg::FIFO_AW-1:0]    r_rd_ptr;
    logic [cll_pkg::FIFO_AW:0]      r_fill;
    logic                           w_rd;
    cll_pkg::t_res                  w_head;

    assign w_rd   = o_result.valid && o_result.ready;
    assign w_head = r_mem[r_rd_ptr];
    assign o_fill = r_fill;

    assign o_result.valid       = (r_fill != '0);
    assign o_result.status      = w_head.status;
    assign o_result.token_kind  = w_head.kind;
    assign o_result.start_col   = w_head.col;
    assign o_result.span_len    = w_head.span;
    assign o_result.result_last = w_head.last;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cll_pkg::RES_MAX; k++) begin
            if (k < int'(i_wr.cnt)) begin
                r_mem[r_wr_ptr + cll_pkg::FIFO_AW'(k)] <= i_wr.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + cll_pkg::FIFO_AW'(i_wr.cnt);
            r_rd_ptr <= r_rd_ptr + cll_pkg::FIFO_AW'(w_rd);
            r_fill   <= r_fill + (cll_pkg::FIFO_AW + 1)'(i_wr.cnt)
                               - (cll_pkg::FIFO_AW + 1)'(w_rd);
        end
    end

endmodule

### sv/command_line_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_lexer_top
// Streaming maximal-munch lexer for command lines, one character per word.
// ----------------------------------------------------------------------------
// Takes one character per cycle with no stall of its own: each character is
// registered, stepped through the lexer in the next cycle, and its zero to
// three results land in an eight-word result queue. The input side only
// holds off (ready low) when the queue might not have room for the worst
// case of three results from both the character in the input register and
// the next one, so sustained rate is set by how fast the sink drains result
// words (one per cycle at best). The first result of a character passes the
// input register and then the result queue before it is offered to the sink.
// Results are tokens (kind, start column, length), errors (invalid char,
// dangling minus, second point; the rest of the line is then silent) and an
// end-of-line word that closes every line. result_last marks the final word
// caused by one character. A minus is resolved one character later. Columns
// saturate at 4095.
// ----------------------------------------------------------------------------
module command_line_lexer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cll_char_if.sink      i_char,
    cll_result_if.source  o_result
);

    cll_pkg::t_wr              w_wr;      // results of the character in process
    logic [cll_pkg::FIFO_AW:0] w_fill;    // queue occupancy, for input flow control

    cll_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_fill  (w_fill),
        .o_wr    (w_wr)
    );

    cll_rfifo u_rfifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .o_fill   (w_fill),
        .o_result (o_result)
    );

endmodule
